// ===== sv/lcbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared types, constants and digit helpers of the card number check.
// ----------------------------------------------------------------------------
package lcbc_pkg;

    localparam int CARD_W          = 63;
    localparam int BCD_DIGITS      = 19;
    localparam int BCD_W           = BCD_DIGITS * 4;
    localparam int BITS_PER_STAGE  = 3;
    localparam int NUM_STAGES      = CARD_W / BITS_PER_STAGE;
    localparam int GROUP_SIZE      = 5;
    localparam int NUM_GROUPS      = (BCD_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int COUNT_W         = 5;
    localparam int GROUP_W         = 6;
    localparam int TOTAL_W         = 8;
    localparam int MULT10_COUNT    = 18;

    typedef logic [3:0] digit_t;

    typedef enum logic [1:0] {
        BRAND_INVALID = 2'd0,
        BRAND_AMEX    = 2'd1,
        BRAND_MASTER  = 2'd2,
        BRAND_VISA    = 2'd3
    } brand_t;

    // value a digit contributes when it sits at a doubled position
    function automatic digit_t luhn_double(input digit_t d);
        digit_t dd;
        dd = {d[2:0], 1'b0};
        if (d >= 4'd5) begin
            dd = dd - 4'd9;
        end
        return dd;
    endfunction

    function automatic logic is_mult10(input logic [TOTAL_W-1:0] t);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < MULT10_COUNT; k++) begin
            if (t == TOTAL_W'(k * 10)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lcbc_bcd_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbc_bcd_stage
// One registered stage of the shift-and-add-3 binary to decimal converter,
// consuming three binary bits per stage.
// ----------------------------------------------------------------------------
module lcbc_bcd_stage import lcbc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [BCD_W-1:0]  in_bcd,
    input  wire logic [CARD_W-1:0] in_bin,
    output logic                   out_valid,
    output logic [BCD_W-1:0]       out_bcd,
    output logic [CARD_W-1:0]      out_bin
);

    logic              valid_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [CARD_W-1:0] bin_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [CARD_W-1:0] bin_next;

    always_comb begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int i = 0; i < BCD_DIGITS; i++) begin
                if (bcd_next[4*i +: 4] >= 4'd5) begin
                    bcd_next[4*i +: 4] = bcd_next[4*i +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[CARD_W-1]};
            bin_next = {bin_next[CARD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;

endmodule
`default_nettype wire

// ===== sv/lcbc_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbc_check
// Luhn digit values, digit count, issuer class and the digit sum, spread
// over three register stages.
// ----------------------------------------------------------------------------
module lcbc_check import lcbc_pkg::*; #(
    parameter int MAX_DIGITS = 19
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [BCD_W-1:0]   in_bcd,
    output logic                    out_valid,
    output brand_t                  out_brand,
    output logic                    out_luhn_ok,
    output logic [COUNT_W-1:0]      out_digit_count
);

    // stage a: per-digit contributions, digit count, leading digits
    logic                a_valid_reg;
    digit_t              a_lv_reg [BCD_DIGITS];
    digit_t              a_lv_next [BCD_DIGITS];
    logic [COUNT_W-1:0]  a_nd_reg;
    logic [COUNT_W-1:0]  a_nd_next;
    logic [COUNT_W-1:0]  a_ndsat_reg;
    logic [COUNT_W-1:0]  a_ndsat_next;
    digit_t              a_d12_reg;
    digit_t              a_d13_reg;
    digit_t              a_d14_reg;
    digit_t              a_d15_reg;

    // stage b: group sums, issuer class
    logic                b_valid_reg;
    logic [GROUP_W-1:0]  b_grp_reg [NUM_GROUPS];
    logic [GROUP_W-1:0]  b_grp_next [NUM_GROUPS];
    brand_t              b_brand_reg;
    brand_t              b_brand_next;
    logic [COUNT_W-1:0]  b_nd_reg;

    // stage c: total
    logic                c_valid_reg;
    logic [TOTAL_W-1:0]  c_total_reg;
    logic [TOTAL_W-1:0]  c_total_next;
    brand_t              c_brand_reg;
    logic [COUNT_W-1:0]  c_nd_reg;

    always_comb begin
        a_nd_next = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (in_bcd[4*i +: 4] != 4'd0) begin
                a_nd_next = COUNT_W'(i + 1);
            end
            if (i >= MAX_DIGITS) begin
                a_lv_next[i] = 4'd0;
            end else if ((i % 2) == 1) begin
                a_lv_next[i] = luhn_double(in_bcd[4*i +: 4]);
            end else begin
                a_lv_next[i] = in_bcd[4*i +: 4];
            end
        end
        if (a_nd_next > COUNT_W'(MAX_DIGITS)) begin
            a_ndsat_next = COUNT_W'(MAX_DIGITS);
        end else begin
            a_ndsat_next = a_nd_next;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            b_grp_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < BCD_DIGITS) begin
                    b_grp_next[g] = b_grp_next[g] +
                                    GROUP_W'(a_lv_reg[g * GROUP_SIZE + j]);
                end
            end
        end
        // issuer prefix ranges map onto digit count and leading digits
        b_brand_next = BRAND_INVALID;
        if (a_nd_reg == COUNT_W'(15) && a_d14_reg == 4'd3 &&
            (a_d13_reg == 4'd4 || a_d13_reg == 4'd7)) begin
            b_brand_next = BRAND_AMEX;
        end else if (a_nd_reg == COUNT_W'(16) && a_d15_reg == 4'd5 &&
                     a_d14_reg >= 4'd1 && a_d14_reg <= 4'd5) begin
            b_brand_next = BRAND_MASTER;
        end else if ((a_nd_reg == COUNT_W'(13) && a_d12_reg == 4'd4) ||
                     (a_nd_reg == COUNT_W'(16) && a_d15_reg == 4'd4)) begin
            b_brand_next = BRAND_VISA;
        end
    end

    always_comb begin
        c_total_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            c_total_next = c_total_next + TOTAL_W'(b_grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_lv_reg    <= a_lv_next;
            a_nd_reg    <= a_nd_next;
            a_ndsat_reg <= a_ndsat_next;
            a_d12_reg   <= in_bcd[4*12 +: 4];
            a_d13_reg   <= in_bcd[4*13 +: 4];
            a_d14_reg   <= in_bcd[4*14 +: 4];
            a_d15_reg   <= in_bcd[4*15 +: 4];
            b_grp_reg   <= b_grp_next;
            b_brand_reg <= b_brand_next;
            b_nd_reg    <= a_ndsat_reg;
            c_total_reg <= c_total_next;
            c_brand_reg <= b_brand_reg;
            c_nd_reg    <= b_nd_reg;
        end
    end

    assign out_valid       = c_valid_reg;
    assign out_luhn_ok     = is_mult10(c_total_reg);
    assign out_brand       = out_luhn_ok ? c_brand_reg : BRAND_INVALID;
    assign out_digit_count = c_nd_reg;

endmodule
`default_nettype wire

// ===== sv/luhn_card_brand_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luhn_card_brand_check
// Luhn mod-10 check and issuer classification of a binary card number.
// ----------------------------------------------------------------------------
// Takes one card number per cycle while s_axis_tready is high and returns its
// brand, Luhn result and decimal digit count through 21 stages of the binary
// to decimal converter (three bits per stage), three stages of digit sum and
// classification, and the output register. Results come out in input order,
// one per input. While a result waits on m_axis_tready the whole pipeline
// holds and s_axis_tready is low.
module luhn_card_brand_check import lcbc_pkg::*; #(
    parameter int MAX_DIGITS = 19
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [62:0] card_number
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [1:0] brand, [2] luhn_ok, [7:3] digit_count
);

    logic               en;
    logic               valid_pipe [NUM_STAGES+1];
    logic [BCD_W-1:0]   bcd_pipe   [NUM_STAGES+1];
    logic [CARD_W-1:0]  bin_pipe   [NUM_STAGES+1];

    logic               chk_valid;
    brand_t             chk_brand;
    logic               chk_ok;
    logic [COUNT_W-1:0] chk_count;

    logic               m_valid_reg;
    brand_t             m_brand_reg;
    logic               m_ok_reg;
    logic [COUNT_W-1:0] m_count_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign valid_pipe[0] = s_axis_tvalid;
    assign bcd_pipe[0]   = '0;
    assign bin_pipe[0]   = s_axis_tdata[CARD_W-1:0];

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_bcd
        lcbc_bcd_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_pipe[g]),
            .in_bcd    (bcd_pipe[g]),
            .in_bin    (bin_pipe[g]),
            .out_valid (valid_pipe[g+1]),
            .out_bcd   (bcd_pipe[g+1]),
            .out_bin   (bin_pipe[g+1])
        );
    end

    lcbc_check #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (valid_pipe[NUM_STAGES]),
        .in_bcd          (bcd_pipe[NUM_STAGES]),
        .out_valid       (chk_valid),
        .out_brand       (chk_brand),
        .out_luhn_ok     (chk_ok),
        .out_digit_count (chk_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= chk_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_brand_reg <= chk_brand;
            m_ok_reg    <= chk_ok;
            m_count_reg <= chk_count;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_count_reg, m_ok_reg, m_brand_reg};

`ifndef SYNTHESIS
    a_brand_needs_luhn : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_brand_reg == BRAND_INVALID || m_ok_reg))
        else $error("brand reported on a failed luhn check");

    a_count_saturated : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_count_reg <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count above limit");

    a_amex_length : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_brand_reg == BRAND_AMEX) |-> (m_count_reg == COUNT_W'(15)))
        else $error("amex result without 15 digits");

    a_master_length : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_brand_reg == BRAND_MASTER) |-> (m_count_reg == COUNT_W'(16)))
        else $error("mastercard result without 16 digits");

    a_visa_length : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_brand_reg == BRAND_VISA) |->
        (m_count_reg == COUNT_W'(13) || m_count_reg == COUNT_W'(16)))
        else $error("visa result without 13 or 16 digits");
`endif

endmodule
`default_nettype wire
